@@ rtl/ps2mct_pkg.sv @@
// Shared types and constants for the PS/2 mouse cursor tracker.
package ps2mct_pkg;

  // Sub-cell steps per text cell on each axis
  localparam int X_SUBSTEPS = 4;
  localparam int Y_SUBSTEPS = 8;

  // Mouse acknowledge byte, never a valid header
  localparam logic [7:0] MOUSE_ACK = 8'hFA;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_COLUMNS = 2'd0,
    CFG_SCREEN_ROWS    = 2'd1
  } cfg_idx_t;

  // Reset values of the configuration registers
  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [7:0] ROWS_RESET    = 8'd25;

  // Movement handed from the packet framer to the cursor update
  typedef struct packed {
    logic              last;  // current byte completes a packet
    logic signed [8:0] dx;    // sign-extended X movement
    logic signed [8:0] dy;    // sign-extended Y movement
  } move_t;

endpackage

@@ rtl/ps2mct_framer.sv @@
// Packet framer: header check, sign capture and X byte holding.
module ps2mct_framer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic [7:0]          rx_byte,
  output ps2mct_pkg::move_t   move
);
  import ps2mct_pkg::*;

  typedef enum logic [1:0] {
    AWAIT_HDR = 2'd0,
    AWAIT_X   = 2'd1,
    AWAIT_Y   = 2'd2
  } phase_t;

  phase_t     phase_r;
  logic [1:0] sign_bits_r;
  logic [7:0] held_dx_r;
  logic       header_ok;

  // Accept a header only with bit 3 set and bits 6 and 7 clear
  assign header_ok = (rx_byte != 8'd0) && (rx_byte != MOUSE_ACK) &&
                     rx_byte[3] && !rx_byte[6] && !rx_byte[7];

  // Present movement of the packet completed by the current byte
  assign move.last = (phase_r == AWAIT_Y);
  assign move.dx   = {sign_bits_r[0], held_dx_r};
  assign move.dy   = {sign_bits_r[1], rx_byte};

  // Advance the packet phase on each processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= AWAIT_HDR;
      sign_bits_r <= 2'b00;
      held_dx_r   <= 8'd0;
    end else if (advance) begin
      case (phase_r)
        AWAIT_X: begin
          held_dx_r <= rx_byte;
          phase_r   <= AWAIT_Y;
        end
        AWAIT_Y: begin
          phase_r <= AWAIT_HDR;
        end
        default: begin
          if (header_ok) begin
            sign_bits_r <= rx_byte[5:4];
            phase_r     <= AWAIT_X;
          end else begin
            phase_r <= AWAIT_HDR;
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/ps2mct_axis.sv @@
// One cursor axis: add a signed movement and saturate to 0 .. top.
module ps2mct_axis (
  input  logic              [10:0] pos,
  input  logic signed       [9:0]  delta,
  input  logic              [10:0] top,
  output logic              [10:0] pos_nxt
);
  import ps2mct_pkg::*;

  logic signed [12:0] sum;

  // Widen both operands so the sum never wraps
  assign sum = signed'({2'b00, pos}) + 13'(delta);

  // Clamp below at zero and above at the range limit
  always_comb begin
    if (sum[12]) begin
      pos_nxt = 11'd0;
    end else if (sum[11:0] > {1'b0, top}) begin
      pos_nxt = top;
    end else begin
      pos_nxt = sum[10:0];
    end
  end

endmodule

@@ rtl/ps2_mouse_cursor_tracker_core.sv @@
// PS/2 mouse cursor tracker top level.
// The Y byte passes through the input register and then the output register before its result appears on out_valid.
// Throughput: one byte per cycle while the input does not stall, through the single input register and output register.
// Input and output are parted by the output register; input stalls only when a
// completing byte meets a held, stalled result.
// Reset (rst_n, synchronous): cursor at 0,0, awaiting header, 80 columns by 25 rows.
module ps2_mouse_cursor_tracker_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [9:0]                        out_fine_x,
  output logic [10:0]                       out_fine_y,
  output logic [7:0]                        out_cell_column,
  output logic [7:0]                        out_cell_row,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ps2mct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                        cfg_data
);
  import ps2mct_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        in_accept, out_free, s1_fire;
  move_t       mv;

  logic [7:0]  columns_r, rows_r;
  logic [7:0]  columns_eff, rows_eff;
  logic [10:0] top_x, top_y;

  logic [9:0]  cursor_x_r;
  logic [10:0] cursor_y_r;
  logic signed [9:0] delta_x, dy_ext, delta_y;
  logic [10:0] new_x, new_y;

  logic        out_valid_r, out_valid_nxt;
  logic [9:0]  fine_x_r;
  logic [10:0] fine_y_r;
  logic [7:0]  cell_column_r, cell_row_r;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLUMNS_RESET;
      rows_r    <= ROWS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCREEN_COLUMNS: columns_r <= cfg_data;
        CFG_SCREEN_ROWS:    rows_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Treat a zero dimension as one cell
  assign columns_eff = (columns_r == 8'd0) ? 8'd1 : columns_r;
  assign rows_eff    = (rows_r == 8'd0) ? 8'd1 : rows_r;
  assign top_x = 11'(32'(columns_eff) * X_SUBSTEPS - 1);
  assign top_y = 11'(32'(rows_eff) * Y_SUBSTEPS - 1);

  // Input register: process the held byte unless its result has nowhere to go
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && (!mv.last || out_free);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // Packet framing
  ps2mct_framer u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_fire),
    .rx_byte (s1_byte_r),
    .move    (mv)
  );

  // X moves right on positive, Y moves down on negative mouse Y
  assign delta_x = 10'(mv.dx);
  assign dy_ext  = 10'(mv.dy);
  assign delta_y = -dy_ext;

  logic [10:0] axis_x_out;

  ps2mct_axis u_axis_x (
    .pos     ({1'b0, cursor_x_r}),
    .delta   (delta_x),
    .top     (top_x),
    .pos_nxt (axis_x_out)
  );
  assign new_x = axis_x_out;

  ps2mct_axis u_axis_y (
    .pos     (cursor_y_r),
    .delta   (delta_y),
    .top     (top_y),
    .pos_nxt (new_y)
  );

  // Cursor state: update on each completed packet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= 10'd0;
      cursor_y_r <= 11'd0;
    end else if (s1_fire && mv.last) begin
      cursor_x_r <= new_x[9:0];
      cursor_y_r <= new_y;
    end
  end

  // Output register: load on a completed packet, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && mv.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && mv.last) begin
      fine_x_r      <= new_x[9:0];
      fine_y_r      <= new_y;
      cell_column_r <= 8'(new_x / X_SUBSTEPS);
      cell_row_r    <= 8'(new_y / Y_SUBSTEPS);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_fine_x      = fine_x_r;
  assign out_fine_y      = fine_y_r;
  assign out_cell_column = cell_column_r;
  assign out_cell_row    = cell_row_r;

  // A stalled input always has a byte waiting in the input register
  a_stall_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  // A completed packet always produces a result in the next cycle
  a_packet_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && mv.last) |=> out_valid)
    else $error("completed packet produced no result");

  // A held result is the cursor state it was computed with
  a_result_tracks_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fine_x == cursor_x_r && out_fine_y == cursor_y_r))
    else $error("result does not match cursor state");

endmodule
